@@ rtl/lqws_pkg.sv @@
// Package for the linear queue with search: widths, codes and state types.
`timescale 1ns / 1ps

package lqws_pkg;

  // Default number of slots
  localparam int unsigned DEPTH_DEFAULT = 16;

  // Field widths
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 4;

  // Packed stream widths
  localparam int unsigned IN_DATA_W  = 2 * VALUE_W;
  localparam int unsigned OUT_DATA_W = 40;

  // Operation codes carried on the input tuser
  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_CHANGE = 2'd3
  } action_e;

  // Result codes carried on the output tuser
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_SCAN = 2'd2,
    S_DONE = 2'd3
  } state_e;

endpackage

@@ rtl/linear_queue_with_search.sv @@
// Top level of the linear queue with search: slot memory, scan sequencer, output register.
`timescale 1ns / 1ps

// Non-circular queue of DEPTH slots with insert, delete, find and change.
// Input channel s_axis: tuser carries the operation, tdata the value (or key)
// and the replacement value. Output channel m_axis: tuser carries the status,
// tdata the data word and slot position, tlast marks the final item of the
// results that one input item causes.
// One input item is worked at a time. Insert and operations on an empty queue
// push their result from S_EXEC, delete from its first S_SCAN step. Find and
// change compare one slot per cycle while the scan is not held, through the
// single registered read port of the slot memory, from the front to the last
// filled slot; S_DONE closes a find or a miss. A find issues one item per
// match, held back one match so that the last one carries tlast.
// The result sits in an output register; the next input item is accepted while
// it waits. When the receiver stalls, the sequencer holds wherever it needs to
// emit another item, and resumes when the output register frees up.
// Reset clears the front index and fill count (empty queue); slot contents
// are undefined until written, and no clearing pass is needed.
module linear_queue_with_search #(
  parameter int unsigned DEPTH = lqws_pkg::DEPTH_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input item: tdata = {new_value[63:32], value[31:0]}, tuser = action
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [lqws_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  input  logic [lqws_pkg::ACTION_W-1:0]        s_axis_tuser,
  // Result item: tdata = {zero[39:36], position[35:32], data[31:0]},
  // tuser = status, tlast = last
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [lqws_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic [lqws_pkg::STATUS_W-1:0]        m_axis_tuser,
  output logic                                 m_axis_tlast
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned VW = lqws_pkg::VALUE_W;
  localparam int unsigned PW = lqws_pkg::POS_W;

  // Sequencer and queue pointers
  lqws_pkg::state_e  state_q, state_d;
  logic [CW-1:0]     front_q, front_d;
  logic [CW-1:0]     filled_q, filled_d;
  logic [CW-1:0]     idx_q, idx_d;

  // Latched input item
  lqws_pkg::action_e act_q;
  logic [VW-1:0]     key_q, repl_q;

  // Held find match
  logic              pend_valid_q, pend_valid_d;
  logic [VW-1:0]     pend_data_q, pend_data_d;
  logic [CW-1:0]     pend_pos_q, pend_pos_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  lqws_pkg::status_e out_status_q;
  logic [VW-1:0]     out_data_q;
  logic [PW-1:0]     out_pos_q;
  logic              out_last_q;

  // Slot memory
  logic [VW-1:0]     mem [DEPTH];
  logic [VW-1:0]     rd_data_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [VW-1:0]     mem_wdata;

  // Result push
  logic              push;
  lqws_pkg::status_e push_status;
  logic [VW-1:0]     push_data;
  logic [CW-1:0]     push_pos;
  logic              push_last;

  logic              in_acc;
  logic              out_free;
  logic              is_empty;
  logic              is_full;
  logic              match;
  logic              scan_end;
  logic              scan_stall;

  assign s_axis_tready = (state_q == lqws_pkg::S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign is_empty      = (front_q >= filled_q);
  assign is_full       = (filled_q == CW'(DEPTH));
  assign match         = (rd_data_q == key_q);
  assign scan_end      = ((idx_q + CW'(1)) >= filled_q);

  // Hold the scan whenever an item must go out and the output is busy
  always_comb begin
    scan_stall = 1'b0;
    case (act_q)
      lqws_pkg::ACT_DELETE: scan_stall = !out_free;
      lqws_pkg::ACT_FIND:   scan_stall = match && pend_valid_q && !out_free;
      lqws_pkg::ACT_CHANGE: scan_stall = match && !out_free;
      default:              scan_stall = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lqws_pkg::S_IDLE: begin
        if (in_acc) state_d = lqws_pkg::S_EXEC;
      end
      lqws_pkg::S_EXEC: begin
        if (act_q == lqws_pkg::ACT_INSERT || is_empty) begin
          if (out_free) state_d = lqws_pkg::S_IDLE;
        end else begin
          state_d = lqws_pkg::S_SCAN;
        end
      end
      lqws_pkg::S_SCAN: begin
        if (!scan_stall) begin
          if (act_q == lqws_pkg::ACT_DELETE) begin
            state_d = lqws_pkg::S_IDLE;
          end else if (act_q == lqws_pkg::ACT_CHANGE && match) begin
            state_d = lqws_pkg::S_IDLE;
          end else if (scan_end) begin
            state_d = lqws_pkg::S_DONE;
          end
        end
      end
      lqws_pkg::S_DONE: begin
        if (out_free) state_d = lqws_pkg::S_IDLE;
      end
      default: state_d = lqws_pkg::S_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    push         = 1'b0;
    push_status  = lqws_pkg::ST_OK;
    push_data    = '0;
    push_pos     = '0;
    push_last    = 1'b1;
    idx_d        = idx_q;
    front_d      = front_q;
    filled_d     = filled_q;
    pend_valid_d = pend_valid_q;
    pend_data_d  = pend_data_q;
    pend_pos_d   = pend_pos_q;
    mem_we       = 1'b0;
    mem_waddr    = filled_q[AW-1:0];
    mem_wdata    = key_q;
    unique case (state_q)
      lqws_pkg::S_IDLE: begin
        pend_valid_d = 1'b0;
      end
      lqws_pkg::S_EXEC: begin
        idx_d = front_q;
        if (act_q == lqws_pkg::ACT_INSERT) begin
          if (out_free) begin
            push = 1'b1;
            if (is_full) begin
              push_status = lqws_pkg::ST_FULL;
            end else begin
              mem_we   = 1'b1;
              filled_d = filled_q + CW'(1);
            end
          end
        end else if (is_empty) begin
          push        = out_free;
          push_status = lqws_pkg::ST_EMPTY;
        end
      end
      lqws_pkg::S_SCAN: begin
        if (!scan_stall) begin
          case (act_q)
            lqws_pkg::ACT_DELETE: begin
              push      = 1'b1;
              push_data = rd_data_q;
              front_d   = front_q + CW'(1);
            end
            lqws_pkg::ACT_CHANGE: begin
              if (match) begin
                push      = 1'b1;
                push_data = rd_data_q;
                push_pos  = idx_q;
                mem_we    = 1'b1;
                mem_waddr = idx_q[AW-1:0];
                mem_wdata = repl_q;
              end else begin
                idx_d = idx_q + CW'(1);
              end
            end
            default: begin
              // Find: release the held match, keep this one back
              if (match) begin
                push         = pend_valid_q;
                push_data    = pend_data_q;
                push_pos     = pend_pos_q;
                push_last    = 1'b0;
                pend_valid_d = 1'b1;
                pend_data_d  = rd_data_q;
                pend_pos_d   = idx_q;
              end
              idx_d = idx_q + CW'(1);
            end
          endcase
        end
      end
      lqws_pkg::S_DONE: begin
        push = out_free;
        if (pend_valid_q) begin
          push_data = pend_data_q;
          push_pos  = pend_pos_q;
        end else begin
          push_status = lqws_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  assign out_valid_d = push || (out_valid_q && !m_axis_tready);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lqws_pkg::S_IDLE;
      front_q      <= '0;
      filled_q     <= '0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      front_q      <= front_d;
      filled_q     <= filled_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q  <= lqws_pkg::action_e'(s_axis_tuser);
      key_q  <= s_axis_tdata[VW-1:0];
      repl_q <= s_axis_tdata[2*VW-1:VW];
    end
    pend_data_q <= pend_data_d;
    pend_pos_q  <= pend_pos_d;
    if (push) begin
      out_status_q <= push_status;
      out_data_q   <= push_data;
      out_pos_q    <= PW'(push_pos);
      out_last_q   <= push_last;
    end
  end

  // Slot memory: one write port, one registered read port that follows the scan index
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_q <= mem[idx_d[AW-1:0]];
  end

  // Drive the output channel
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {(lqws_pkg::OUT_DATA_W - VW - PW)'(0), out_pos_q, out_data_q};

endmodule

@@ test/lqws_checker.sv @@
// Checker for the linear queue with search: predicts result items and compares them.
`timescale 1ns / 1ps

module lqws_checker #(
  parameter int unsigned DEPTH = lqws_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input item: tdata = {new_value, value}, tuser = action
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [lqws_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic [lqws_pkg::ACTION_W-1:0]     s_axis_tuser,
  // Result item: tdata = {zero, position, data}, tuser = status, tlast = last
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [lqws_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic [lqws_pkg::STATUS_W-1:0]     m_axis_tuser,
  input  logic                              m_axis_tlast,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o,
  output int unsigned                       results_o
);
  import lqws_pkg::*;

  localparam int unsigned MAX_PRINTS = 40;

  typedef struct packed {
    status_e           status;
    logic [VALUE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic              last;
  } result_t;

  // Shadow of the queue contents and pointers
  logic [VALUE_W-1:0] slot_mem [DEPTH];
  int unsigned        head_idx;
  int unsigned        fill_cnt;
  result_t            expected_results [$];

  function automatic result_t make_result(status_e st, logic [VALUE_W-1:0] d,
                                          logic [POS_W-1:0] p, logic l);
    result_t r;
    r.status = st;
    r.data   = d;
    r.pos    = p;
    r.last   = l;
    return r;
  endfunction

  // Print one line per mismatch (up to a cap) and count every one
  task automatic report_mismatch(string what, logic [63:0] exp_v, logic [63:0] got_v);
    if (fail_count_o < MAX_PRINTS) begin
      $display("%0t ns: result %0d, %s: expected %h, got %h",
               $time, results_o, what, exp_v, got_v);
    end
    fail_count_o++;
  endtask

  // Work out the result items that one accepted input item causes
  task automatic predict_response(action_e act, logic [VALUE_W-1:0] key,
                                  logic [VALUE_W-1:0] repl);
    result_t     held;
    bit          have_held;
    bit          done;
    int unsigned i;
    have_held = 1'b0;
    done      = 1'b0;
    if (act == ACT_INSERT) begin
      if (fill_cnt >= DEPTH) begin
        expected_results.push_back(make_result(ST_FULL, '0, '0, 1'b1));
      end else begin
        slot_mem[fill_cnt] = key;
        fill_cnt++;
        expected_results.push_back(make_result(ST_OK, '0, '0, 1'b1));
      end
    end else if (head_idx >= fill_cnt) begin
      expected_results.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
    end else begin
      case (act)
        ACT_DELETE: begin
          expected_results.push_back(make_result(ST_OK, slot_mem[head_idx], '0, 1'b1));
          head_idx++;
        end
        ACT_FIND: begin
          // Hold each match back by one so the final one carries last
          for (i = head_idx; i < fill_cnt; i++) begin
            if (slot_mem[i] == key) begin
              if (have_held) expected_results.push_back(held);
              held      = make_result(ST_OK, slot_mem[i], i[POS_W-1:0], 1'b0);
              have_held = 1'b1;
            end
          end
          if (have_held) begin
            held.last = 1'b1;
            expected_results.push_back(held);
          end else begin
            expected_results.push_back(make_result(ST_NOTFOUND, '0, '0, 1'b1));
          end
        end
        default: begin
          // Change: replace the first match only
          for (i = head_idx; i < fill_cnt && !done; i++) begin
            if (slot_mem[i] == key) begin
              expected_results.push_back(make_result(ST_OK, slot_mem[i], i[POS_W-1:0],
                                                     1'b1));
              slot_mem[i] = repl;
              done        = 1'b1;
            end
          end
          if (!done) expected_results.push_back(make_result(ST_NOTFOUND, '0, '0, 1'b1));
        end
      endcase
    end
  endtask

  // Compare one accepted result item with the oldest expectation
  task automatic check_result();
    result_t exp_r;
    if (expected_results.size() == 0) begin
      report_mismatch("result item with nothing expected", '0,
                      {m_axis_tuser, m_axis_tlast, m_axis_tdata});
    end else begin
      exp_r = expected_results.pop_front();
      if (m_axis_tuser != exp_r.status)
        report_mismatch("status", exp_r.status, m_axis_tuser);
      if (m_axis_tdata[VALUE_W-1:0] != exp_r.data)
        report_mismatch("data", exp_r.data, m_axis_tdata[VALUE_W-1:0]);
      if (m_axis_tdata[VALUE_W+POS_W-1:VALUE_W] != exp_r.pos)
        report_mismatch("position", exp_r.pos, m_axis_tdata[VALUE_W+POS_W-1:VALUE_W]);
      if (m_axis_tlast != exp_r.last)
        report_mismatch("last", exp_r.last, m_axis_tlast);
      if (m_axis_tdata[OUT_DATA_W-1:VALUE_W+POS_W] != '0)
        report_mismatch("tdata padding", '0, m_axis_tdata[OUT_DATA_W-1:VALUE_W+POS_W]);
    end
    results_o++;
  endtask

  // Watch both channels; results first, then the new input item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_idx = 0;
      fill_cnt = 0;
      expected_results.delete();
      pending_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) begin
        predict_response(action_e'(s_axis_tuser), s_axis_tdata[VALUE_W-1:0],
                         s_axis_tdata[2*VALUE_W-1:VALUE_W]);
      end
      pending_o = expected_results.size();
    end
  end

endmodule

@@ test/linear_queue_with_search_tb.sv @@
// Testbench top for the linear queue with search: stimulus, handshake pressure and verdict.
`timescale 1ns / 1ps

module linear_queue_with_search_tb;
  import lqws_pkg::*;

  localparam int unsigned DEPTH       = DEPTH_DEFAULT;
  localparam int unsigned RANDOM_ITEMS = 420;
  localparam int unsigned PHASE_ITEMS = RANDOM_ITEMS / 4;
  localparam int unsigned DRAIN_CYCLES = 24;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    s_valid = 1'b0;
  logic                    s_ready;
  logic [IN_DATA_W-1:0]    s_data = '0;
  logic [ACTION_W-1:0]     s_user = '0;
  logic                    m_valid;
  logic                    m_ready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_data;
  logic [STATUS_W-1:0]     m_user;
  logic                    m_last;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_seen;

  // Pressure knobs, in percent of cycles
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  // Rough view of queue occupancy, only used to shape the stimulus
  int unsigned items_sent = 0;
  int unsigned inserts_taken = 0;
  int unsigned deletes_taken = 0;

  linear_queue_with_search #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tuser (m_user),
    .m_axis_tlast (m_last)
  );

  lqws_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tuser (m_user),
    .m_axis_tlast (m_last),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results_seen)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: stall at random according to the current phase
  always @(negedge clk) begin
    m_ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  // Small set of values so that finds hit several slots, with the extremes in it
  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(9) >= 6) return $urandom();
    case ($urandom_range(4))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0009;
      default: return 32'h0000_0000;
    endcase
  endfunction

  // Present one item, with random idle cycles ahead of it, and wait for acceptance
  task automatic send_item(action_e act, logic [VALUE_W-1:0] val, logic [VALUE_W-1:0] repl);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {repl, val};
    s_user  <= act;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    items_sent++;
    if (act == ACT_INSERT && inserts_taken < DEPTH) inserts_taken++;
    if (act == ACT_DELETE && deletes_taken < inserts_taken) deletes_taken++;
  endtask

  // Random item: inserts while slots remain, few deletes until the tail of the run
  task automatic send_random_item(bit tail_part);
    int unsigned ins_w;
    int unsigned del_w;
    int unsigned r;
    action_e     act;
    ins_w = (inserts_taken < DEPTH) ? 35 : 8;
    del_w = tail_part ? 40 : 3;
    r = $urandom_range(99);
    if (r < ins_w) act = ACT_INSERT;
    else if (r < ins_w + del_w) act = ACT_DELETE;
    else act = $urandom_range(1) ? ACT_FIND : ACT_CHANGE;
    send_item(act, pick_value(), pick_value());
  endtask

  // Main stimulus
  initial begin
    int unsigned n;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty queue first, then extremes, duplicates, hits and misses
    send_item(ACT_DELETE, 32'h0000_0000, $urandom());
    send_item(ACT_FIND,   32'h0000_0009, $urandom());
    send_item(ACT_CHANGE, 32'h0000_0009, 32'h0000_0001);
    send_item(ACT_INSERT, 32'h8000_0000, $urandom());
    send_item(ACT_INSERT, 32'h7FFF_FFFF, $urandom());
    send_item(ACT_INSERT, 32'h0000_0000, $urandom());
    send_item(ACT_INSERT, 32'hFFFF_FFFF, $urandom());
    send_item(ACT_INSERT, 32'h7FFF_FFFF, $urandom());
    send_item(ACT_FIND,   32'h7FFF_FFFF, $urandom());
    send_item(ACT_FIND,   32'h0000_0009, $urandom());
    send_item(ACT_CHANGE, 32'hFFFF_FFFF, 32'h8000_0000);
    send_item(ACT_FIND,   32'h8000_0000, $urandom());
    send_item(ACT_DELETE, $urandom(),    $urandom());
    send_item(ACT_FIND,   32'h8000_0000, $urandom());
    send_item(ACT_CHANGE, 32'h1234_5678, 32'h0000_0000);
    send_item(ACT_FIND,   32'h0000_0000, $urandom());

    // Random: four pressure phases; the tail favours deletes to drain the queue
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      case (n / PHASE_ITEMS)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 57; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      send_random_item(n >= RANDOM_ITEMS - 60);
    end

    // Wait for the last results, then a few more cycles for stray items
    @(negedge clk);
    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d items (16 directed) under four idle/stall mixes; checked %0d results.",
             items_sent, results_seen);
    $display("Queue slots filled: %0d of %0d, deleted: %0d; mismatches: %0d.",
             inserts_taken, DEPTH, deletes_taken, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Timeout with %0d results still expected.", pending);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
